>>> hw/rtl/dtw_pkg.sv
// ----------------------------------------------------------------------------
// dtw_pkg
// Shared widths, depths and register indexes for the trigger window generator.
// ----------------------------------------------------------------------------
package dtw_pkg;

	localparam int DELAY_DEPTH = 64;
	localparam int DELAY_AW    = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;
	localparam int FILL_W      = $clog2(DELAY_DEPTH + 1);

	localparam int SAMPLE_W = 16;
	localparam int TICK_W   = 32;
	localparam int DELAY_W  = 6;
	localparam int THR_W    = 16;
	localparam int PRE_W    = 16;
	localparam int LEN_W    = 16;

	// width for the circular read address math
	localparam int PTR_CALC_W = ((DELAY_AW > DELAY_W) ? DELAY_AW : DELAY_W) + 1;

	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_DELAY_TICKS    = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_RISE_THRESHOLD = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_PRE_TRIGGER    = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH  = CFG_IDX_W'(3);

	localparam logic [DELAY_W-1:0] DELAY_TICKS_RST    = DELAY_W'(4);
	localparam logic [THR_W-1:0]   RISE_THRESHOLD_RST = THR_W'(100);
	localparam logic [PRE_W-1:0]   PRE_TRIGGER_RST    = PRE_W'(0);
	localparam logic [LEN_W-1:0]   WINDOW_LENGTH_RST  = LEN_W'(1000);

endpackage

>>> hw/rtl/dtw_in_if.sv
// ----------------------------------------------------------------------------
// dtw_in_if
// Sample stream channel: one ADC sample with its tick and range-end mark.
// ----------------------------------------------------------------------------
interface dtw_in_if;
	import dtw_pkg::*;

	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] sample;
	logic [TICK_W-1:0]   tick;
	logic                last_of_range;

	modport source(output valid, sample, tick, last_of_range, input ready);
	modport sink(input valid, sample, tick, last_of_range, output ready);
endinterface

>>> hw/rtl/dtw_out_if.sv
// ----------------------------------------------------------------------------
// dtw_out_if
// Window channel: start and end tick of one readout window.
// ----------------------------------------------------------------------------
interface dtw_out_if;
	import dtw_pkg::*;

	logic              valid;
	logic              ready;
	logic [TICK_W-1:0] window_start;
	logic [TICK_W-1:0] window_end;
	logic              cut_at_range_end;

	modport source(output valid, window_start, window_end, cut_at_range_end, input ready);
	modport sink(input valid, window_start, window_end, cut_at_range_end, output ready);
endinterface

>>> hw/rtl/dtw_cfg_if.sv
// ----------------------------------------------------------------------------
// dtw_cfg_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface dtw_cfg_if;
	import dtw_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

>>> hw/rtl/dtw_delay_line.sv
// ----------------------------------------------------------------------------
// dtw_delay_line
// Circular sample buffer. Each write also reads the sample lag writes back;
// read data is registered and comes from before the same-cycle write.
// ----------------------------------------------------------------------------
module dtw_delay_line (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr_en,
	input  logic [dtw_pkg::SAMPLE_W-1:0] wr_data,
	input  logic [dtw_pkg::DELAY_W-1:0]  lag,
	output logic [dtw_pkg::SAMPLE_W-1:0] rd_data
);
	import dtw_pkg::*;

	logic [SAMPLE_W-1:0]   mem [DELAY_DEPTH];
	logic [DELAY_AW-1:0]   wptr_q;
	logic [PTR_CALC_W-1:0] ra_wide;
	logic [PTR_CALC_W-1:0] ra_fold;
	logic [DELAY_AW-1:0]   ra;

	// lag never exceeds the depth, so one fold brings the address in range
	always_comb begin
		ra_wide = PTR_CALC_W'(wptr_q) + PTR_CALC_W'(DELAY_DEPTH) - PTR_CALC_W'(lag);
		if (ra_wide >= PTR_CALC_W'(DELAY_DEPTH)) begin
			ra_fold = ra_wide - PTR_CALC_W'(DELAY_DEPTH);
		end else begin
			ra_fold = ra_wide;
		end
		ra = ra_fold[DELAY_AW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
		end else if (wr_en) begin
			if (32'(wptr_q) == DELAY_DEPTH - 1) begin
				wptr_q <= '0;
			end else begin
				wptr_q <= wptr_q + DELAY_AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			rd_data     <= mem[ra];
			mem[wptr_q] <= wr_data;
		end
	end

endmodule

>>> hw/rtl/derivative_trigger_windows.sv
// ----------------------------------------------------------------------------
// derivative_trigger_windows
// Self-trigger window generator: opens a readout window when a sample rises
// above its delayed copy by more than the threshold, emits it once closed.
// ----------------------------------------------------------------------------
// The sample that closes a window is registered in the compare stage (buffer
// read and compare), then the window in the output register. One sample per
// cycle while the output takes windows; the buffer reads and writes each beat.
// Reset: registers take their default values, the window state and sample
// count clear at once; buffer contents stay unknown and are never used.
// ----------------------------------------------------------------------------
module derivative_trigger_windows (
	input  logic      clk,
	input  logic      arst_n,
	dtw_cfg_if.sink   cfg,
	dtw_in_if.sink    samples,
	dtw_out_if.source windows
);
	import dtw_pkg::*;

	// configuration
	logic [DELAY_W-1:0] delay_q;
	logic [THR_W-1:0]   thr_q;
	logic [PRE_W-1:0]   pre_q;
	logic [LEN_W-1:0]   len_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= DELAY_TICKS_RST;
			thr_q   <= RISE_THRESHOLD_RST;
			pre_q   <= PRE_TRIGGER_RST;
			len_q   <= WINDOW_LENGTH_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_DELAY_TICKS:    delay_q <= cfg.data[DELAY_W-1:0];
				REG_RISE_THRESHOLD: thr_q   <= cfg.data[THR_W-1:0];
				REG_PRE_TRIGGER:    pre_q   <= cfg.data[PRE_W-1:0];
				REG_WINDOW_LENGTH:  len_q   <= cfg.data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// input side
	logic                in_beat;
	logic [DELAY_W-1:0]  lag;
	logic [FILL_W-1:0]   fill_q;
	logic [PRE_W:0]      back_sum;
	logic [SAMPLE_W-1:0] old_rd;

	assign in_beat = samples.valid && samples.ready;
	assign lag     = (32'(delay_q) > DELAY_DEPTH) ? DELAY_W'(DELAY_DEPTH) : delay_q;
	assign back_sum = (PRE_W+1)'(lag) + (PRE_W+1)'(pre_q);

	dtw_delay_line u_delay (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (in_beat),
		.wr_data (samples.sample),
		.lag     (lag),
		.rd_data (old_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (in_beat) begin
			if (samples.last_of_range) begin
				fill_q <= '0;
			end else if (32'(fill_q) < DELAY_DEPTH) begin
				fill_q <= fill_q + FILL_W'(1);
			end
		end
	end

	// compare stage
	logic                valid_s1;
	logic [SAMPLE_W-1:0] sample_s1;
	logic                last_s1;
	logic                cmp_s1;
	logic                self_s1;
	logic [TICK_W:0]     earlier_s1;  // two's complement, may go negative
	logic [TICK_W+1:0]   base_s1;     // earlier - pre_trigger
	logic [TICK_W-1:0]   tick_m1_s1;

	logic                firing_q;
	logic [TICK_W-1:0]   open_start_q;
	logic [TICK_W-1:0]   open_end_q;

	logic [SAMPLE_W-1:0] old_s1;
	logic [SAMPLE_W:0]   rise;
	logic                crossed;
	logic                reached;
	logic [TICK_W+1:0]   end_sum;
	logic [TICK_W-1:0]   end_clamp;
	logic [TICK_W-1:0]   start_clamp;
	logic                s1_res;
	logic                s1_go;
	logic                s1_fire;
	logic                out_free;

	logic                out_valid_q;
	logic [TICK_W-1:0]   win_start_q;
	logic [TICK_W-1:0]   win_end_q;
	logic                win_cut_q;

	always_comb begin
		old_s1  = self_s1 ? sample_s1 : old_rd;
		rise    = {1'b0, sample_s1} - {1'b0, old_s1};
		crossed = !rise[SAMPLE_W] && (rise[SAMPLE_W-1:0] > thr_q);
		reached = !earlier_s1[TICK_W] && (earlier_s1[TICK_W-1:0] >= open_end_q);

		end_sum = base_s1 + (TICK_W+2)'(len_q);
		if (end_sum[TICK_W+1]) begin
			end_clamp = '0;
		end else if (end_sum[TICK_W]) begin
			end_clamp = '1;
		end else begin
			end_clamp = end_sum[TICK_W-1:0];
		end
		start_clamp = base_s1[TICK_W+1] ? '0 : base_s1[TICK_W-1:0];

		if (last_s1) begin
			s1_res = firing_q;
		end else begin
			s1_res = cmp_s1 && !crossed && firing_q && reached;
		end
	end

	assign out_free      = !out_valid_q || windows.ready;
	assign s1_go         = !valid_s1 || !s1_res || out_free;
	assign s1_fire       = valid_s1 && s1_go;
	assign samples.ready = s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_go) begin
			valid_s1 <= in_beat;
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			sample_s1  <= samples.sample;
			last_s1    <= samples.last_of_range;
			cmp_s1     <= 32'(fill_q) >= 32'(lag);
			self_s1    <= (lag == '0);
			earlier_s1 <= {1'b0, samples.tick} - (TICK_W+1)'(lag);
			base_s1    <= {2'b00, samples.tick} - (TICK_W+2)'(back_sum);
			tick_m1_s1 <= (samples.tick == '0) ? '0 : samples.tick - TICK_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			firing_q     <= 1'b0;
			open_start_q <= '0;
			open_end_q   <= '0;
		end else if (s1_fire) begin
			if (last_s1) begin
				firing_q     <= 1'b0;
				open_start_q <= '0;
				open_end_q   <= '0;
			end else if (cmp_s1) begin
				if (crossed) begin
					firing_q   <= 1'b1;
					open_end_q <= end_clamp;
					if (!firing_q) begin
						open_start_q <= start_clamp;
					end
				end else if (firing_q && reached) begin
					firing_q <= 1'b0;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire && s1_res) begin
			out_valid_q <= 1'b1;
		end else if (windows.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && s1_res) begin
			win_start_q <= open_start_q;
			win_end_q   <= last_s1 ? tick_m1_s1 : open_end_q;
			win_cut_q   <= last_s1;
		end
	end

	assign windows.valid            = out_valid_q;
	assign windows.window_start     = win_start_q;
	assign windows.window_end       = win_end_q;
	assign windows.cut_at_range_end = win_cut_q;

endmodule
